>>> sv/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg
// Shared types, sizes and the control store of the heap sort engine.
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W   = $clog2(MAX_ITEMS);
  localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
  localparam int CHILD_W = CNT_W + 1;
  localparam int PC_W    = 5;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value_res;
    logic                         last_res;
    logic                         overflow;
  } out_item_t;

  // request from the sequencer to the element store
  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic                  re;
    logic [IDX_W-1:0]      raddr;
  } store_req_t;

  typedef enum logic [4:0] {
    OP_NONE       = 5'd0,
    OP_LOAD       = 5'd1,
    OP_BUILD_INIT = 5'd2,
    OP_BUILD_NEXT = 5'd3,
    OP_RD_NODE    = 5'd4,
    OP_RD_LC      = 5'd5,
    OP_CMP_LC     = 5'd6,
    OP_CMP_RC     = 5'd7,
    OP_WR_NODE    = 5'd8,
    OP_WR_TOP     = 5'd9,
    OP_EXT_INIT   = 5'd10,
    OP_RD_ROOT    = 5'd11,
    OP_RD_K       = 5'd12,
    OP_WR_ROOT    = 5'd13,
    OP_WR_K       = 5'd14,
    OP_OUT_INIT   = 5'd15,
    OP_OUT_RD     = 5'd16,
    OP_PUSH       = 5'd17,
    OP_FINISH     = 5'd18
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT       = 3'd0,
    C_ALWAYS     = 3'd1,
    C_STAY_LOAD  = 3'd2,
    C_K_ZERO     = 3'd3,
    C_SIFT_DONE  = 3'd4,
    C_NOT_PUSHED = 3'd5,
    C_K_LT_N     = 3'd6
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  localparam logic [PC_W-1:0] STEP_LOAD       = 5'd0;
  localparam logic [PC_W-1:0] STEP_BUILD_INIT = 5'd1;
  localparam logic [PC_W-1:0] STEP_BUILD_LOOP = 5'd2;
  localparam logic [PC_W-1:0] STEP_SIFT_RD    = 5'd3;
  localparam logic [PC_W-1:0] STEP_SIFT_LC    = 5'd4;
  localparam logic [PC_W-1:0] STEP_SIFT_RC    = 5'd5;
  localparam logic [PC_W-1:0] STEP_SIFT_CMP   = 5'd6;
  localparam logic [PC_W-1:0] STEP_SIFT_SWAP1 = 5'd7;
  localparam logic [PC_W-1:0] STEP_SIFT_SWAP2 = 5'd8;
  localparam logic [PC_W-1:0] STEP_EXT_INIT   = 5'd9;
  localparam logic [PC_W-1:0] STEP_EXT_LOOP   = 5'd10;
  localparam logic [PC_W-1:0] STEP_EXT_RD_K   = 5'd11;
  localparam logic [PC_W-1:0] STEP_EXT_WR0    = 5'd12;
  localparam logic [PC_W-1:0] STEP_EXT_WRK    = 5'd13;
  localparam logic [PC_W-1:0] STEP_OUT_INIT   = 5'd14;
  localparam logic [PC_W-1:0] STEP_OUT_RD     = 5'd15;
  localparam logic [PC_W-1:0] STEP_OUT_PUSH   = 5'd16;
  localparam logic [PC_W-1:0] STEP_OUT_NEXT   = 5'd17;
  localparam logic [PC_W-1:0] STEP_FINISH     = 5'd18;

  // control store: one word per step, jump taken when cond holds
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t cw;
    cw = '{op: OP_NONE, cond: C_ALWAYS, target: STEP_LOAD};
    case (pc)
      STEP_LOAD:       cw = '{op: OP_LOAD,       cond: C_STAY_LOAD,  target: STEP_LOAD};
      STEP_BUILD_INIT: cw = '{op: OP_BUILD_INIT, cond: C_NEXT,       target: STEP_LOAD};
      STEP_BUILD_LOOP: cw = '{op: OP_BUILD_NEXT, cond: C_K_ZERO,     target: STEP_EXT_INIT};
      STEP_SIFT_RD:    cw = '{op: OP_RD_NODE,    cond: C_NEXT,       target: STEP_LOAD};
      STEP_SIFT_LC:    cw = '{op: OP_RD_LC,      cond: C_NEXT,       target: STEP_LOAD};
      STEP_SIFT_RC:    cw = '{op: OP_CMP_LC,     cond: C_NEXT,       target: STEP_LOAD};
      STEP_SIFT_CMP:   cw = '{op: OP_CMP_RC,     cond: C_NEXT,       target: STEP_LOAD};
      STEP_SIFT_SWAP1: cw = '{op: OP_WR_NODE,    cond: C_SIFT_DONE,  target: STEP_LOAD};
      STEP_SIFT_SWAP2: cw = '{op: OP_WR_TOP,     cond: C_ALWAYS,     target: STEP_SIFT_RD};
      STEP_EXT_INIT:   cw = '{op: OP_EXT_INIT,   cond: C_NEXT,       target: STEP_LOAD};
      STEP_EXT_LOOP:   cw = '{op: OP_RD_ROOT,    cond: C_K_ZERO,     target: STEP_OUT_INIT};
      STEP_EXT_RD_K:   cw = '{op: OP_RD_K,       cond: C_NEXT,       target: STEP_LOAD};
      STEP_EXT_WR0:    cw = '{op: OP_WR_ROOT,    cond: C_NEXT,       target: STEP_LOAD};
      STEP_EXT_WRK:    cw = '{op: OP_WR_K,       cond: C_ALWAYS,     target: STEP_SIFT_RD};
      STEP_OUT_INIT:   cw = '{op: OP_OUT_INIT,   cond: C_NEXT,       target: STEP_LOAD};
      STEP_OUT_RD:     cw = '{op: OP_OUT_RD,     cond: C_NEXT,       target: STEP_LOAD};
      STEP_OUT_PUSH:   cw = '{op: OP_PUSH,       cond: C_NOT_PUSHED, target: STEP_OUT_PUSH};
      STEP_OUT_NEXT:   cw = '{op: OP_NONE,       cond: C_K_LT_N,     target: STEP_OUT_RD};
      STEP_FINISH:     cw = '{op: OP_FINISH,     cond: C_ALWAYS,     target: STEP_LOAD};
      default:         cw = '{op: OP_NONE,       cond: C_ALWAYS,     target: STEP_LOAD};
    endcase
    return cw;
  endfunction

endpackage

>>> sv/hse_store.sv
// ----------------------------------------------------------------------------
// hse_store
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hse_store (
  input  logic                           clk,
  input  hse_pkg::store_req_t            req,
  output logic [hse_pkg::VALUE_BITS-1:0] rd_data
);

  logic [hse_pkg::VALUE_BITS-1:0] mem [hse_pkg::MAX_ITEMS];
  logic [hse_pkg::VALUE_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/heap_sort_engine.sv
// ----------------------------------------------------------------------------
// heap_sort_engine
// Collects a set of signed values and returns it sorted ascending (heapsort).
// ----------------------------------------------------------------------------
// Input beats (in_data.value, in_data.last) are stored one per cycle while the
// engine is loading; in_data.last closes the set. Beats beyond MAX_ITEMS are
// dropped and every result of that set carries overflow. After the closing
// beat the engine stops taking input, sorts the set in place and streams it
// out ascending, out_data.last_res on the final beat.
// The sort runs from a microcoded control store over an element store with
// one read and one write port. A sift-down level that swaps reads the node,
// reads its two children, compares, and makes two writes (node, then the
// larger child's slot); the level where it stops makes only the node write.
// Each build step is one loop step plus one sift-down; each extraction reads
// the root and element k, writes them back swapped and runs one sift-down of
// up to log2(N) levels. Each output beat reads an element, pushes it and
// advances the index.
// A stalled receiver holds the result in the output register and freezes
// the sequencer at the push step; the final result may still wait while the
// next set loads. Reset (rst_n low, synchronous) empties the set, clears the
// overflow flag and the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module heap_sort_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hse_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hse_pkg::out_item_t  out_data
);

  localparam logic [hse_pkg::CNT_W-1:0] CNT_MAX = hse_pkg::CNT_W'(hse_pkg::MAX_ITEMS);

  hse_pkg::ctrl_t     cw;
  hse_pkg::store_req_t sreq;
  logic [hse_pkg::VALUE_BITS-1:0] rd_data;

  logic [hse_pkg::PC_W-1:0]  pc_r, pc_nxt;
  logic [hse_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [hse_pkg::CNT_W-1:0] k_r, k_nxt;
  logic [hse_pkg::CNT_W-1:0] size_r, size_nxt;
  logic [hse_pkg::IDX_W-1:0] node_r, node_nxt;
  logic [hse_pkg::IDX_W-1:0] top_r, top_nxt;
  logic signed [hse_pkg::VALUE_BITS-1:0] vnode_r, vnode_nxt;
  logic signed [hse_pkg::VALUE_BITS-1:0] vtop_r, vtop_nxt;
  logic                      phase_r, phase_nxt;
  logic                      out_valid_r, out_valid_nxt;
  hse_pkg::out_item_t        out_data_r, out_data_nxt;

  logic                        in_fire;
  logic                        out_free;
  logic                        pushed;
  logic                        jump;
  logic [hse_pkg::CHILD_W-1:0] lc;
  logic [hse_pkg::CHILD_W-1:0] rc;
  logic                        lc_ok;
  logic                        rc_ok;

  assign cw       = hse_pkg::ucode(pc_r);
  assign in_ready = (cw.op == hse_pkg::OP_LOAD);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign pushed   = (cw.op == hse_pkg::OP_PUSH) && out_free;

  assign lc    = (hse_pkg::CHILD_W'(node_r) << 1) + hse_pkg::CHILD_W'(1);
  assign rc    = lc + hse_pkg::CHILD_W'(1);
  assign lc_ok = lc < hse_pkg::CHILD_W'(size_r);
  assign rc_ok = rc < hse_pkg::CHILD_W'(size_r);

  hse_store u_store (
    .clk     (clk),
    .req     (sreq),
    .rd_data (rd_data)
  );

  // datapath
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    k_nxt     = k_r;
    size_nxt  = size_r;
    node_nxt  = node_r;
    top_nxt   = top_r;
    vnode_nxt = vnode_r;
    vtop_nxt  = vtop_r;
    phase_nxt = phase_r;
    sreq      = '0;
    case (cw.op)
      hse_pkg::OP_LOAD: begin
        if (in_fire) begin
          if (count_r < CNT_MAX) begin
            sreq.we    = 1'b1;
            sreq.waddr = count_r[hse_pkg::IDX_W-1:0];
            sreq.wdata = in_data.value;
            count_nxt  = count_r + hse_pkg::CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      hse_pkg::OP_BUILD_INIT: begin
        k_nxt     = count_r >> 1;
        size_nxt  = count_r;
        phase_nxt = 1'b0;
      end
      hse_pkg::OP_BUILD_NEXT: begin
        k_nxt    = k_r - hse_pkg::CNT_W'(1);
        node_nxt = k_nxt[hse_pkg::IDX_W-1:0];
      end
      hse_pkg::OP_RD_NODE: begin
        sreq.re    = 1'b1;
        sreq.raddr = node_r;
        top_nxt    = node_r;
      end
      hse_pkg::OP_RD_LC: begin
        vnode_nxt  = rd_data;
        vtop_nxt   = rd_data;
        sreq.re    = 1'b1;
        sreq.raddr = lc[hse_pkg::IDX_W-1:0];
      end
      hse_pkg::OP_CMP_LC: begin
        if (lc_ok && ($signed(rd_data) > vtop_r)) begin
          top_nxt  = lc[hse_pkg::IDX_W-1:0];
          vtop_nxt = rd_data;
        end
        sreq.re    = 1'b1;
        sreq.raddr = rc[hse_pkg::IDX_W-1:0];
      end
      hse_pkg::OP_CMP_RC: begin
        if (rc_ok && ($signed(rd_data) > vtop_r)) begin
          top_nxt  = rc[hse_pkg::IDX_W-1:0];
          vtop_nxt = rd_data;
        end
      end
      hse_pkg::OP_WR_NODE: begin
        // rewrites the same value when the node already is the largest
        sreq.we    = 1'b1;
        sreq.waddr = node_r;
        sreq.wdata = vtop_r;
      end
      hse_pkg::OP_WR_TOP: begin
        sreq.we    = 1'b1;
        sreq.waddr = top_r;
        sreq.wdata = vnode_r;
        node_nxt   = top_r;
      end
      hse_pkg::OP_EXT_INIT: begin
        k_nxt     = count_r - hse_pkg::CNT_W'(1);
        phase_nxt = 1'b1;
      end
      hse_pkg::OP_RD_ROOT: begin
        sreq.re    = 1'b1;
        sreq.raddr = '0;
      end
      hse_pkg::OP_RD_K: begin
        vnode_nxt  = rd_data;
        sreq.re    = 1'b1;
        sreq.raddr = k_r[hse_pkg::IDX_W-1:0];
      end
      hse_pkg::OP_WR_ROOT: begin
        sreq.we    = 1'b1;
        sreq.waddr = '0;
        sreq.wdata = rd_data;
      end
      hse_pkg::OP_WR_K: begin
        sreq.we    = 1'b1;
        sreq.waddr = k_r[hse_pkg::IDX_W-1:0];
        sreq.wdata = vnode_r;
        size_nxt   = k_r;
        k_nxt      = k_r - hse_pkg::CNT_W'(1);
        node_nxt   = '0;
      end
      hse_pkg::OP_OUT_INIT: begin
        k_nxt = '0;
      end
      hse_pkg::OP_OUT_RD: begin
        sreq.re    = 1'b1;
        sreq.raddr = k_r[hse_pkg::IDX_W-1:0];
      end
      hse_pkg::OP_PUSH: begin
        if (out_free) begin
          k_nxt = k_r + hse_pkg::CNT_W'(1);
        end
      end
      hse_pkg::OP_FINISH: begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pushed) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.value_res = rd_data;
      out_data_nxt.last_res  = (k_r + hse_pkg::CNT_W'(1)) == count_r;
      out_data_nxt.overflow  = ovf_r;
    end
  end

  // sequencer
  always_comb begin
    case (cw.cond)
      hse_pkg::C_NEXT:       jump = 1'b0;
      hse_pkg::C_ALWAYS:     jump = 1'b1;
      hse_pkg::C_STAY_LOAD:  jump = !(in_fire && in_data.last);
      hse_pkg::C_K_ZERO:     jump = (k_r == '0);
      hse_pkg::C_SIFT_DONE:  jump = (top_r == node_r);
      hse_pkg::C_NOT_PUSHED: jump = !out_free;
      hse_pkg::C_K_LT_N:     jump = (k_r < count_r);
      default:               jump = 1'b1;
    endcase
    if (!jump) begin
      pc_nxt = pc_r + hse_pkg::PC_W'(1);
    end else if (cw.cond == hse_pkg::C_SIFT_DONE) begin
      // return from the sift-down to the loop that called it
      pc_nxt = phase_r ? hse_pkg::STEP_EXT_LOOP : hse_pkg::STEP_BUILD_LOOP;
    end else begin
      pc_nxt = cw.target;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= hse_pkg::STEP_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    size_r     <= size_nxt;
    node_r     <= node_nxt;
    top_r      <= top_nxt;
    vnode_r    <= vnode_nxt;
    vtop_r     <= vtop_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("element count beyond capacity");

  a_out_index: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == hse_pkg::STEP_OUT_RD) |-> (k_r < count_r))
    else $error("output read beyond the held set");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pushed && out_data_nxt.last_res) |=> ##1 (pc_r == hse_pkg::STEP_FINISH))
    else $error("final result not followed by set release");

  a_no_load_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.last) |=> !in_ready)
    else $error("input taken while sorting");

endmodule
